// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the RTL in this folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, disabled while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked on every rising clock edge, disabled while reset is low.
`define ASSERT_IMPLY(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

`endif

// ----- rtl/core/tqi_pkg.sv -----
// ----------------------------------------------------------------------------
// Table quadratic interpolator package
// Types, widths and codes shared by the interpolator RTL.
// ----------------------------------------------------------------------------
package tqi_pkg;

  // Fixed-point sample width (signed Q16.16) and difference width.
  localparam int unsigned FX_W   = 32;
  localparam int unsigned DIFF_W = FX_W + 1;

  // Exact numerator and denominator arithmetic width.
  localparam int unsigned ACC_W     = 136;
  localparam int unsigned DIV_CNT_W = $clog2(ACC_W);
  localparam int unsigned MUL_CNT_W = $clog2(FX_W);

  // Width of a signed result before saturation.
  localparam int unsigned SUM_W = FX_W + 3;

  // Request kinds.
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Result status codes.
  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_NOBR = 2'd1;
  localparam logic [1:0] STATUS_REP  = 2'd2;
  localparam logic [1:0] STATUS_SAT  = 2'd3;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_CHK,
    S_DIFF,
    S_MLD,
    S_MUL,
    S_NEG,
    S_STORE,
    S_ABS,
    S_PREP,
    S_DIV,
    S_FIN,
    S_OUT
  } tqi_state_e;

  // Multiply program steps of the parabola evaluation.
  typedef enum logic [2:0] {
    PH_D1B,
    PH_T1,
    PH_D2A,
    PH_T2V,
    PH_NU,
    PH_AB,
    PH_D
  } tqi_phase_e;

endpackage

// ----- rtl/core/tqi_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tqi_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- rtl/core/table_quadratic_interpolator.sv -----
// ----------------------------------------------------------------------------
// Table quadratic interpolator
// Three-point parabola through a loaded table, evaluated at a query abscissa.
// ----------------------------------------------------------------------------
// Usage: each request on the slave stream is either a load (tuser = 0), which
// writes one (x, y) point into the table and gives no result, or a query
// (tuser = 1), which gives one result on the master stream: the value of the
// parabola through the first bracketing triple, with a status code.
// The point count register is written through cfg_we_i / cfg_wdata_i; the user
// writes it only while the block is idle (the block does not enforce this).
// A query scans the table one entry at a time, reading it in S_RD and checking
// it in S_CHK (one RAM read port, registered read), then runs seven shift-add
// multiplies on one shared adder and a 136-step restoring division.
// The block takes no request while a query is in work.
// A finished result waits in an output register; when the receiver stalls,
// the next load is still taken, and a next query stalls only at its end.
// Reset clears the control state and the point count; table contents are
// undefined until loaded.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module table_quadratic_interpolator
  import tqi_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [8:0]   cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [7:0] point_index, [39:8] point_x, [71:40] point_y, [103:72] query_x
  input  logic [103:0] s_axis_tdata,
  // [0] mode
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] fitted_value
  output logic [31:0]  m_axis_tdata,
  // [1:0] status
  output logic [1:0]   m_axis_tuser
);

  localparam int unsigned AW    = $clog2(TABLE_DEPTH);
  localparam int unsigned CMP_W = (AW + 1 > 9) ? AW + 1 : 9;
  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(TABLE_DEPTH);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(ACC_W - 1);
  localparam logic [MUL_CNT_W-1:0] MUL_LAST = MUL_CNT_W'(FX_W - 1);

  tqi_state_e state_q, state_d;
  tqi_phase_e ph_q;

  logic [8:0]       pts_q;
  logic [CMP_W-1:0] k_q, n_eff, idx_ext, pts_ext;

  // Request fields.
  logic [7:0]           in_idx;
  logic signed [FX_W-1:0] in_x, in_y, in_q;
  assign in_idx = s_axis_tdata[7:0];
  assign in_x   = s_axis_tdata[39:8];
  assign in_y   = s_axis_tdata[71:40];
  assign in_q   = s_axis_tdata[103:72];

  logic s_acc;
  assign s_acc = s_axis_tvalid && s_axis_tready;

  // Table RAM: x in the upper half, y in the lower half.
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_raddr;
  logic [63:0]   ram_rdata;

  assign idx_ext = CMP_W'(in_idx);
  assign ram_we  = s_acc && (s_axis_tuser == MODE_LOAD) && (idx_ext < DEPTH_C);

  tqi_ram #(
    .WIDTH(64),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(idx_ext[AW-1:0]),
    .wdata_i({in_x, in_y}),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Effective point count.
  assign pts_ext = CMP_W'(pts_q);
  assign n_eff   = (pts_ext > DEPTH_C) ? DEPTH_C : pts_ext;

  // Sliding window of three points and the query abscissa.
  logic signed [FX_W-1:0] w_x_q [3];
  logic signed [FX_W-1:0] w_y_q [3];
  logic signed [FX_W-1:0] q_q;
  logic signed [FX_W-1:0] rd_x, rd_y;
  assign rd_x = ram_rdata[63:32];
  assign rd_y = ram_rdata[31:0];

  logic hit, rep;
  assign hit = (k_q >= CMP_W'(2)) && (w_x_q[1] <= q_q) && (q_q <= rd_x);
  assign rep = (w_x_q[1] == w_x_q[2]) || (w_x_q[2] == rd_x) || (w_x_q[1] == rd_x);

  // Differences of the chosen triple.
  logic signed [DIFF_W-1:0] da_q, db_q, dc_q, du_q, dv_q, d1_q, d2_q;

  // Shared shift-add multiplier and accumulators.
  logic signed [ACC_W-1:0] mcand_q, prod_q, r1_q, r2_q;
  logic [FX_W-1:0]         mplier_q;
  logic                    msign_q;
  logic [MUL_CNT_W-1:0]    mcnt_q;

  logic signed [ACC_W-1:0]  sel_mcand;
  logic signed [DIFF_W-1:0] sel_mplier, mplier_abs;

  always_comb begin
    case (ph_q)
      PH_D1B:  begin sel_mcand = ACC_W'(d1_q); sel_mplier = db_q; end
      PH_T1:   begin sel_mcand = r1_q;         sel_mplier = dc_q; end
      PH_D2A:  begin sel_mcand = ACC_W'(d2_q); sel_mplier = da_q; end
      PH_T2V:  begin sel_mcand = r1_q;         sel_mplier = dv_q; end
      PH_NU:   begin sel_mcand = r1_q;         sel_mplier = du_q; end
      PH_AB:   begin sel_mcand = ACC_W'(da_q); sel_mplier = db_q; end
      PH_D:    begin sel_mcand = r2_q;         sel_mplier = dc_q; end
      default: begin sel_mcand = r2_q;         sel_mplier = dc_q; end
    endcase
  end
  assign mplier_abs = sel_mplier[DIFF_W-1] ? -sel_mplier : sel_mplier;

  // Restoring divider.
  logic [ACC_W-1:0]     p_q, den_q, rem_q, quo_q, rem_sh;
  logic [DIV_CNT_W-1:0] dcnt_q;
  logic                 neg_q;
  assign rem_sh = {rem_q[ACC_W-2:0], p_q[ACC_W-1]};

  // Final offset and saturation.
  logic signed [SUM_W-1:0] y0_ext, qv_ext, sum;
  logic                    big, ovf_hi, ovf_lo;
  assign big    = |quo_q[ACC_W-1:DIFF_W];
  assign y0_ext = SUM_W'(w_y_q[0]);
  assign qv_ext = SUM_W'({1'b0, quo_q[DIFF_W-1:0]});
  assign sum    = neg_q ? (y0_ext - qv_ext) : (y0_ext + qv_ext);
  assign ovf_hi = !sum[SUM_W-1] && (sum[SUM_W-2:FX_W-1] != '0);
  assign ovf_lo = sum[SUM_W-1] && (sum[SUM_W-2:FX_W-1] != '1);

  // Pending result and output register.
  logic [FX_W-1:0] res_val_q;
  logic [1:0]      res_st_q;
  logic            out_valid_q, out_free;
  logic [FX_W-1:0] out_val_q;
  logic [1:0]      out_st_q;
  assign out_free = !out_valid_q || m_axis_tready;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (s_acc && (s_axis_tuser == MODE_QUERY)) state_d = S_RD;
      S_RD:    state_d = (k_q >= n_eff) ? S_OUT : S_CHK;
      S_CHK: begin
        if (hit) state_d = rep ? S_OUT : S_DIFF;
        else     state_d = S_RD;
      end
      S_DIFF:  state_d = S_MLD;
      S_MLD:   state_d = S_MUL;
      S_MUL:   if (mcnt_q == MUL_LAST) state_d = S_NEG;
      S_NEG:   state_d = S_STORE;
      S_STORE: state_d = (ph_q == PH_D) ? S_ABS : S_MLD;
      S_ABS:   state_d = S_PREP;
      S_PREP:  state_d = S_DIV;
      S_DIV:   if (dcnt_q == DIV_LAST) state_d = S_FIN;
      S_FIN:   state_d = S_OUT;
      S_OUT:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    s_axis_tready = 1'b0;
    ram_re        = 1'b0;
    ram_raddr     = k_q[AW-1:0];
    unique case (state_q)
      S_IDLE:  s_axis_tready = 1'b1;
      S_RD:    ram_re = (k_q < n_eff);
      default: ram_re = 1'b0;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pts_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        pts_q <= cfg_wdata_i;
      end
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        q_q <= in_q;
        k_q <= '0;
      end
      S_RD: begin
        if (k_q >= n_eff) begin
          res_val_q <= '0;
          res_st_q  <= STATUS_NOBR;
        end
      end
      S_CHK: begin
        w_x_q[0] <= w_x_q[1];
        w_x_q[1] <= w_x_q[2];
        w_x_q[2] <= rd_x;
        w_y_q[0] <= w_y_q[1];
        w_y_q[1] <= w_y_q[2];
        w_y_q[2] <= rd_y;
        k_q      <= k_q + CMP_W'(1);
        if (hit && rep) begin
          res_val_q <= '0;
          res_st_q  <= STATUS_REP;
        end
      end
      S_DIFF: begin
        da_q <= DIFF_W'(w_x_q[1]) - DIFF_W'(w_x_q[0]);
        db_q <= DIFF_W'(w_x_q[2]) - DIFF_W'(w_x_q[1]);
        dc_q <= DIFF_W'(w_x_q[2]) - DIFF_W'(w_x_q[0]);
        du_q <= DIFF_W'(q_q) - DIFF_W'(w_x_q[0]);
        dv_q <= DIFF_W'(q_q) - DIFF_W'(w_x_q[1]);
        d1_q <= DIFF_W'(w_y_q[1]) - DIFF_W'(w_y_q[0]);
        d2_q <= DIFF_W'(w_y_q[2]) - DIFF_W'(w_y_q[1]);
        ph_q <= PH_D1B;
      end
      S_MLD: begin
        mcand_q  <= sel_mcand;
        mplier_q <= mplier_abs[FX_W-1:0];
        msign_q  <= sel_mplier[DIFF_W-1];
        prod_q   <= '0;
        mcnt_q   <= '0;
      end
      S_MUL: begin
        if (mplier_q[0]) begin
          prod_q <= prod_q + mcand_q;
        end
        mcand_q  <= mcand_q <<< 1;
        mplier_q <= mplier_q >> 1;
        mcnt_q   <= mcnt_q + MUL_CNT_W'(1);
      end
      S_NEG: begin
        if (msign_q) begin
          prod_q <= -prod_q;
        end
      end
      S_STORE: begin
        // Results of each program step land in the two temporaries.
        case (ph_q)
          PH_D1B:  r1_q <= prod_q;
          PH_T1:   r2_q <= prod_q;
          PH_D2A:  r1_q <= prod_q - r1_q;
          PH_T2V:  r1_q <= r2_q + prod_q;
          PH_NU:   r1_q <= prod_q;
          PH_AB:   r2_q <= prod_q;
          default: r2_q <= prod_q;
        endcase
        ph_q <= tqi_phase_e'(ph_q + 3'd1);
      end
      S_ABS: begin
        p_q   <= r1_q[ACC_W-1] ? -r1_q : r1_q;
        den_q <= r2_q[ACC_W-1] ? -r2_q : r2_q;
        neg_q <= (r1_q != '0) && (r1_q[ACC_W-1] ^ r2_q[ACC_W-1]);
      end
      S_PREP: begin
        // Round half away from zero: (2|N| + |D|) / (2|D|).
        p_q    <= {p_q[ACC_W-2:0], 1'b0} + den_q;
        den_q  <= {den_q[ACC_W-2:0], 1'b0};
        rem_q  <= '0;
        quo_q  <= '0;
        dcnt_q <= '0;
      end
      S_DIV: begin
        if (rem_sh >= den_q) begin
          rem_q <= rem_sh - den_q;
          quo_q <= {quo_q[ACC_W-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          quo_q <= {quo_q[ACC_W-2:0], 1'b0};
        end
        p_q    <= {p_q[ACC_W-2:0], 1'b0};
        dcnt_q <= dcnt_q + DIV_CNT_W'(1);
      end
      S_FIN: begin
        if (big) begin
          res_val_q <= neg_q ? {1'b1, {(FX_W-1){1'b0}}} : {1'b0, {(FX_W-1){1'b1}}};
          res_st_q  <= STATUS_SAT;
        end else if (ovf_hi) begin
          res_val_q <= {1'b0, {(FX_W-1){1'b1}}};
          res_st_q  <= STATUS_SAT;
        end else if (ovf_lo) begin
          res_val_q <= {1'b1, {(FX_W-1){1'b0}}};
          res_st_q  <= STATUS_SAT;
        end else begin
          res_val_q <= sum[FX_W-1:0];
          res_st_q  <= STATUS_OK;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_val_q <= res_val_q;
          out_st_q  <= res_st_q;
        end
      end
      default: begin
        k_q <= k_q;
      end
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_val_q;
  assign m_axis_tuser  = out_st_q;

  // Checks.
  `ASSERT_IMPLY(a_err_zero, clk_i, rst_ni,
                m_axis_tvalid && (m_axis_tuser == STATUS_NOBR || m_axis_tuser == STATUS_REP),
                m_axis_tdata == '0, "error result with nonzero value")
  `ASSERT_IMPLY(a_out_src, clk_i, rst_ni, $rose(out_valid_q),
                $past(state_q == S_OUT), "result shown outside output state")
  `ASSERT_IMPLY(a_den_nz, clk_i, rst_ni, state_q == S_DIV, den_q != '0,
                "division by zero denominator")

endmodule
